// File: src/latency_based_upload_rate_control_unit_macros.svh
// assertion macros used by the checker file
`ifndef LATENCY_BASED_UPLOAD_RATE_CONTROL_UNIT_MACROS_SVH
`define LATENCY_BASED_UPLOAD_RATE_CONTROL_UNIT_MACROS_SVH

// property checked outside reset
`define LBURC_ASSERT_RUN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define LBURC_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/lburc_pkg.sv
`default_nettype none

package lburc_pkg;

    // request codes carried on s_tuser
    typedef enum logic [2:0] {
        ACT_RESET = 3'd0,
        ACT_CALIB = 3'd1,
        ACT_BEGIN = 3'd2,
        ACT_CTRL  = 3'd3,
        ACT_FAST  = 3'd4
    } action_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_USE_MS    = 3'd0,
        REG_TOLERANCE = 3'd1,
        REG_UP_DIV    = 3'd2,
        REG_DOWN_DIV  = 3'd3,
        REG_WIN_LEN   = 3'd4,
        REG_FLOOR     = 3'd5,
        REG_MIN_UP    = 3'd6,
        REG_MAX_UP    = 3'd7
    } cfg_idx_t;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_W       = 31;

    localparam logic [30:0] RATE_MAX = 31'h7FFF_FFFF;
    localparam logic [31:0] HEADROOM = 32'd30720;
    localparam logic [31:0] T20      = 32'd20000;
    localparam logic [31:0] T30      = 32'd30000;
    localparam logic [31:0] T40      = 32'd40000;
    localparam logic [31:0] T60      = 32'd60000;

    // step numerator |hping| * 10240, denominator divisor * baseline
    localparam int NUM_W = 54;
    localparam int DEN_W = 47;
    localparam int TGT_W = 39;
    localparam int HP_W  = 41;

    // control from the sequencer to every window cell
    typedef struct packed {
        logic shift;
        logic load;
        logic run;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: src/lburc_cell.sv
`default_nettype none

module lburc_cell #(
    parameter int WINDOW_MAX = 32,
    parameter int IDX        = 0
) (
    input  wire                            aclk,
    input  wire lburc_pkg::cell_ctl_t      ctl,
    input  wire [15:0]                     ins_val,
    input  wire [15:0]                     ring_val_in,
    input  wire [$clog2(WINDOW_MAX)-1:0]   ring_tag_in,
    input  wire [$clog2(WINDOW_MAX+1)-1:0] count,
    output logic [15:0]                    hold_val,
    output logic [15:0]                    ring_val_out,
    output logic [$clog2(WINDOW_MAX)-1:0]  ring_tag_out,
    output logic [$clog2(WINDOW_MAX)-1:0]  rank
);

    localparam int RW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);

    logic [15:0]   hold_reg;
    logic [15:0]   ring_val_reg;
    logic [RW-1:0] ring_tag_reg;
    logic [RW-1:0] rank_reg;
    logic          own_valid;
    logic          ring_valid;
    logic          ring_less;

    // this entry and the passing entry both lie inside the window
    assign own_valid  = CW'(IDX) < count;
    assign ring_valid = CW'(ring_tag_reg) < count;
    // stable order: equal values rank by position
    assign ring_less  = (ring_val_reg < hold_reg) ||
                        ((ring_val_reg == hold_reg) && (ring_tag_reg < RW'(IDX)));

    // stored delay, rotating copy and rank counter
    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            hold_reg <= ins_val;
        end
        if (ctl.load) begin
            ring_val_reg <= hold_reg;
            ring_tag_reg <= RW'(IDX);
            rank_reg     <= '0;
        end else if (ctl.run) begin
            ring_val_reg <= ring_val_in;
            ring_tag_reg <= ring_tag_in;
            if (own_valid && ring_valid && ring_less) begin
                rank_reg <= rank_reg + RW'(1);
            end
        end
    end

    assign hold_val     = hold_reg;
    assign ring_val_out = ring_val_reg;
    assign ring_tag_out = ring_tag_reg;
    assign rank         = rank_reg;

endmodule

`default_nettype wire

// File: src/lburc_div.sv
`default_nettype none

module lburc_div #(
    parameter int NW = 54,
    parameter int DW = 47
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           start,
    input  wire [NW-1:0]  num,
    input  wire [DW-1:0]  den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int KW = $clog2(NW);

    logic [DW-1:0] rem_reg;
    logic [NW-1:0] nq_reg;
    logic [DW-1:0] den_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    // one quotient bit a cycle, restoring
    assign rem_sh = {rem_reg, nq_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + KW'(1);
                if (cnt_reg == KW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            nq_reg  <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            nq_reg  <= {nq_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

`default_nettype wire

// File: src/latency_based_upload_rate_control_unit.sv
`default_nettype none

// Upload rate limiter steered by ping delay. Each request on s_ carries an
// action (s_tuser) with delay, measured upload and a millisecond time stamp,
// and gives exactly one result on m_: the limit, the accept-new-client flag,
// the window median and the baseline. Reset, calibrate, begin and unused
// codes skip the window and the divider. For a control sample or a fast
// reaction the delay window is a row of WINDOW_MAX cells that rank their
// entries by passing a copy round the ring once, and the rate step comes
// from a restoring divider that yields one of 54 quotient bits a cycle.
// One request is worked on at a time; a new one is taken while the
// previous result still waits on m_.
module latency_based_upload_rate_control_unit #(
    parameter int WINDOW_MAX = 32
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // delay_ms[15:0], cur_upload[46:16], now_ms[78:47], zero pad
    input  wire [lburc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // action[2:0]
    input  wire [2:0]                           s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // upload_limit[30:0], accept_new_client[31], median_ping[47:32],
    // baseline_ping[78:48], zero pad
    output logic [lburc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  wire                                 cfg_we,
    input  wire [2:0]                           cfg_addr,
    input  wire [lburc_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int RW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int NW = lburc_pkg::NUM_W;
    localparam int DW = lburc_pkg::DEN_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_RANK = 9'b000000100,
        S_SEL  = 9'b000001000,
        S_MED  = 9'b000010000,
        S_HP   = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic        use_ms_reg;
    logic [15:0] tol_reg, up_div_reg, down_div_reg, floor_reg;
    logic [5:0]  win_len_reg;
    logic [30:0] min_reg, max_reg;

    // controller state
    logic [30:0]   baseline_reg, rate_reg;
    logic          acc_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   phase_reg;
    logic [15:0]   median_reg;

    // per-sample working registers
    logic [15:0]                    up_sc_reg, dn_sc_reg;
    logic [lburc_pkg::TGT_W-1:0]    target_reg;
    logic [30:0]                    cur_reg;
    logic [RW-1:0]                  step_reg;
    logic [15:0]                    lo_reg, hi_reg;
    logic                           hp_neg_reg, hp_pos_reg;

    // output register
    logic        m_tvalid_reg;
    logic [lburc_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    // request fields
    lburc_pkg::action_t action;
    logic [15:0] in_delay;
    logic [30:0] in_cur;
    logic [31:0] in_now;
    logic        in_take;

    assign action   = lburc_pkg::action_t'(s_tuser);
    assign in_delay = s_tdata[15:0];
    assign in_cur   = s_tdata[46:16];
    assign in_now   = s_tdata[78:47];
    assign s_tready = (state_reg == S_IDLE);
    assign in_take  = s_tvalid && s_tready;

    // window cells
    lburc_pkg::cell_ctl_t cell_ctl;
    logic [15:0]   c_hold [WINDOW_MAX];
    logic [15:0]   c_rval [WINDOW_MAX];
    logic [RW-1:0] c_rtag [WINDOW_MAX];
    logic [RW-1:0] c_rank [WINDOW_MAX];

    logic is_ctrl;
    assign is_ctrl = (action == lburc_pkg::ACT_CTRL) || (action == lburc_pkg::ACT_FAST);

    assign cell_ctl.shift = in_take && is_ctrl;
    assign cell_ctl.load  = (state_reg == S_LOAD);
    assign cell_ctl.run   = (state_reg == S_RANK);

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        lburc_cell #(
            .WINDOW_MAX (WINDOW_MAX),
            .IDX        (i)
        ) u_cell (
            .aclk         (aclk),
            .ctl          (cell_ctl),
            .ins_val      ((i == 0) ? in_delay : c_hold[(i + WINDOW_MAX - 1) % WINDOW_MAX]),
            .ring_val_in  (c_rval[(i + WINDOW_MAX - 1) % WINDOW_MAX]),
            .ring_tag_in  (c_rtag[(i + WINDOW_MAX - 1) % WINDOW_MAX]),
            .count        (count_reg),
            .hold_val     (c_hold[i]),
            .ring_val_out (c_rval[i]),
            .ring_tag_out (c_rtag[i]),
            .rank         (c_rank[i])
        );
    end

    // middle ranks and their values
    logic [RW-1:0] mid_hi, mid_lo;
    logic [15:0]   sel_lo, sel_hi;

    assign mid_hi = RW'(count_reg >> 1);
    assign mid_lo = count_reg[0] ? mid_hi : mid_hi - RW'(1);

    always_comb begin
        sel_lo = '0;
        sel_hi = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (CW'(i) < count_reg) begin
                if (c_rank[i] == mid_lo) sel_lo = sel_lo | c_hold[i];
                if (c_rank[i] == mid_hi) sel_hi = sel_hi | c_hold[i];
            end
        end
    end

    // divisor scaling over the fast period
    function automatic logic [15:0] scale_div(input logic [15:0] d, input logic [1:0] m);
        logic [17:0] p;
        logic [15:0] r;
        p = {2'b00, d} * {16'd0, m};
        r = p[17:2];
        return (r == 16'd0) ? 16'd1 : r;
    endfunction

    logic [31:0]   elapsed;
    logic [1:0]    mul_sel;
    logic          mul_keep;
    logic [46:0]   tgt_prod;
    logic [CW-1:0] len_c;

    assign elapsed  = (action == lburc_pkg::ACT_FAST) ? 32'd0 : in_now - phase_reg;
    assign tgt_prod = {16'd0, baseline_reg} * {31'd0, tol_reg};

    always_comb begin
        mul_keep = 1'b0;
        mul_sel  = 2'd0;
        priority if (elapsed < lburc_pkg::T20) mul_keep = 1'b1;
        else if (elapsed < lburc_pkg::T30) mul_sel = 2'd1;
        else if (elapsed < lburc_pkg::T40) mul_sel = 2'd2;
        else if (elapsed < lburc_pkg::T60) mul_sel = 2'd3;
        else mul_keep = 1'b1;
    end

    // window length forced into 1..WINDOW_MAX
    always_comb begin
        priority if (win_len_reg == 6'd0) len_c = CW'(1);
        else if (32'(win_len_reg) > 32'(WINDOW_MAX)) len_c = CW'(WINDOW_MAX);
        else len_c = CW'(win_len_reg);
    end

    // step numerator and denominator
    logic signed [lburc_pkg::HP_W-1:0] hping;
    logic [lburc_pkg::HP_W-2:0]        hmag;
    logic [NW-1:0]                     num_c;
    logic [30:0]                       base_c;
    logic [15:0]                       div_c;
    logic [DW-1:0]                     den_c;

    assign hping  = $signed({2'b00, target_reg}) - $signed(lburc_pkg::HP_W'(median_reg))
                    + $signed(lburc_pkg::HP_W'(baseline_reg));
    assign hmag   = hping[lburc_pkg::HP_W-1] ? 40'(-hping) : hping[lburc_pkg::HP_W-2:0];
    assign num_c  = (NW'(hmag) << 13) + (NW'(hmag) << 11);
    assign base_c = (baseline_reg == 31'd0) ? 31'd1 : baseline_reg;
    assign div_c  = hping[lburc_pkg::HP_W-1] ? dn_sc_reg : up_sc_reg;
    assign den_c  = {16'd0, base_c} * {31'd0, div_c};

    logic          div_start, div_done;
    logic [NW-1:0] quo;

    assign div_start = (state_reg == S_HP);

    lburc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_c),
        .den     (den_c),
        .done    (div_done),
        .quo     (quo)
    );

    // rate update from the step
    logic [30:0] rate_a, rate_b;
    logic        acc_a, acc_b;

    always_comb begin
        rate_a = rate_reg;
        acc_a  = acc_reg;
        if (hp_neg_reg) begin
            acc_a  = 1'b0;
            rate_a = (quo < NW'(rate_reg)) ? rate_reg - quo[30:0] : 31'd0;
        end else if (hp_pos_reg) begin
            acc_a = 1'b1;
            if ({1'b0, cur_reg} + lburc_pkg::HEADROOM > {1'b0, rate_reg}) begin
                rate_a = (NW'(lburc_pkg::RATE_MAX - rate_reg) > quo)
                         ? rate_reg + quo[30:0] : lburc_pkg::RATE_MAX;
            end
        end
        rate_b = rate_a;
        acc_b  = acc_a;
        if (rate_b < min_reg) begin
            rate_b = min_reg;
            acc_b  = 1'b1;
        end
        if (rate_b > max_reg) rate_b = max_reg;
    end

    // sequencer
    logic fin_load;
    assign fin_load = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_take) state_next = is_ctrl ? S_LOAD : S_FIN;
            S_LOAD: state_next = S_RANK;
            S_RANK: if (step_reg == RW'(WINDOW_MAX - 1)) state_next = S_SEL;
            S_SEL:  state_next = S_MED;
            S_MED:  state_next = S_HP;
            S_HP:   state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_UPD;
            S_UPD:  state_next = S_FIN;
            S_FIN:  if (fin_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_ms_reg   <= 1'b0;
            tol_reg      <= 16'd200;
            up_div_reg   <= 16'd1;
            down_div_reg <= 16'd1;
            win_len_reg  <= 6'd1;
            floor_reg    <= 16'd20;
            min_reg      <= 31'd1024;
            max_reg      <= lburc_pkg::RATE_MAX;
        end else if (cfg_we) begin
            unique case (lburc_pkg::cfg_idx_t'(cfg_addr))
                lburc_pkg::REG_USE_MS:    use_ms_reg   <= cfg_wdata[0];
                lburc_pkg::REG_TOLERANCE: tol_reg      <= cfg_wdata[15:0];
                lburc_pkg::REG_UP_DIV:    up_div_reg   <= cfg_wdata[15:0];
                lburc_pkg::REG_DOWN_DIV:  down_div_reg <= cfg_wdata[15:0];
                lburc_pkg::REG_WIN_LEN:   win_len_reg  <= cfg_wdata[5:0];
                lburc_pkg::REG_FLOOR:     floor_reg    <= cfg_wdata[15:0];
                lburc_pkg::REG_MIN_UP:    min_reg      <= cfg_wdata[30:0];
                lburc_pkg::REG_MAX_UP:    max_reg      <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= lburc_pkg::RATE_MAX;
            rate_reg     <= '0;
            acc_reg      <= 1'b0;
            count_reg    <= '0;
            phase_reg    <= '0;
            median_reg   <= '0;
        end else begin
            if (in_take) begin
                unique case (action)
                    lburc_pkg::ACT_RESET: begin
                        count_reg    <= '0;
                        median_reg   <= '0;
                        baseline_reg <= lburc_pkg::RATE_MAX;
                    end
                    lburc_pkg::ACT_CALIB: begin
                        if (in_delay != 16'd0 && 31'(in_delay) < baseline_reg) begin
                            baseline_reg <= (in_delay > floor_reg) ? 31'(in_delay)
                                                                   : 31'(floor_reg);
                        end
                    end
                    lburc_pkg::ACT_BEGIN: begin
                        if (baseline_reg == lburc_pkg::RATE_MAX) begin
                            baseline_reg <= 31'(floor_reg);
                        end
                        if (in_cur > min_reg) begin
                            rate_reg <= (in_cur < max_reg) ? in_cur : max_reg;
                        end else begin
                            rate_reg <= (min_reg < max_reg) ? min_reg : max_reg;
                        end
                        count_reg  <= '0;
                        median_reg <= '0;
                        phase_reg  <= in_now;
                    end
                    lburc_pkg::ACT_CTRL, lburc_pkg::ACT_FAST: begin
                        if (action == lburc_pkg::ACT_FAST) phase_reg <= in_now;
                        if (in_delay != 16'd0 && 31'(in_delay) < baseline_reg &&
                            baseline_reg > 31'(floor_reg)) begin
                            baseline_reg <= (in_delay > floor_reg) ? 31'(in_delay)
                                                                   : 31'(floor_reg);
                        end
                        count_reg <= (count_reg >= len_c) ? len_c : count_reg + CW'(1);
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_MED) begin
                median_reg <= 16'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
            end
            if (state_reg == S_UPD) begin
                rate_reg <= rate_b;
                acc_reg  <= acc_b;
            end
        end
    end

    // per-sample working registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            up_sc_reg  <= mul_keep ? ((up_div_reg == 16'd0) ? 16'd1 : up_div_reg)
                                   : scale_div(up_div_reg, mul_sel);
            dn_sc_reg  <= mul_keep ? ((down_div_reg == 16'd0) ? 16'd1 : down_div_reg)
                                   : scale_div(down_div_reg, mul_sel);
            target_reg <= use_ms_reg ? lburc_pkg::TGT_W'(tol_reg) : tgt_prod[46:8];
            cur_reg    <= in_cur;
        end
        if (state_reg == S_LOAD) step_reg <= '0;
        else if (state_reg == S_RANK) step_reg <= step_reg + RW'(1);
        if (state_reg == S_SEL) begin
            lo_reg <= sel_lo;
            hi_reg <= sel_hi;
        end
        if (state_reg == S_HP) begin
            hp_neg_reg <= hping[lburc_pkg::HP_W-1];
            hp_pos_reg <= !hping[lburc_pkg::HP_W-1] && (hping != '0);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            m_tdata_reg <= {1'b0, baseline_reg, median_reg, acc_reg, rate_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: src/lburc_chk.sv
`default_nettype none

`include "latency_based_upload_rate_control_unit_macros.svh"

module lburc_chk (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [lburc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // a stalled result keeps its value
    `LBURC_ASSERT_RUN(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    // nothing is offered straight out of reset
    `LBURC_ASSERT_ALL(a_rst_quiet, aclk, !aresetn |=> !m_tvalid, "result offered after reset")

    // one request at a time: busy right after taking one
    `LBURC_ASSERT_RUN(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

    // padding bit of the result stays clear
    `LBURC_ASSERT_RUN(a_pad_zero, aclk, aresetn, m_tvalid |-> !m_tdata[lburc_pkg::OUT_TDATA_W-1], "result padding not zero")

endmodule

bind latency_based_upload_rate_control_unit lburc_chk u_lburc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WMAX = 32;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] delay_ms;
        logic [30:0] cur_upload;
        logic [31:0] now_ms;
    } rate_req_t;

    typedef struct packed {
        logic [30:0] upload_limit;
        logic        accept;
        logic [15:0] median;
        logic [30:0] baseline;
    } rate_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [lburc_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [lburc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [lburc_pkg::CFG_W-1:0] cfg_wdata = '0;

    latency_based_upload_rate_control_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of the registers and state
    logic        p_use_ms;
    logic [15:0] p_tol, p_up_div, p_down_div, p_floor;
    logic [5:0]  p_win_len;
    logic [30:0] p_min_up, p_max_up;
    logic [30:0] p_base, p_rate;
    logic [5:0]  p_count;
    logic [4:0]  p_head;
    logic [31:0] p_start;
    logic        p_accept;
    logic [15:0] p_win [WMAX];

    rate_req_t  req_q [$];
    rate_res_t  limit_q [$];
    int errors = 0;
    bit feed_done = 0;
    bit long_hold = 0;
    bit sender_pause = 0;

    function automatic logic [15:0] window_median();
        logic [15:0] srt [WMAX];
        logic [15:0] v;
        int n, i, j;
        n = p_count;
        if (n == 0) return 16'd0;
        for (i = 0; i < n; i++) srt[i] = p_win[(p_head + i) % WMAX];
        for (i = 1; i < n; i++) begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        if (n % 2) return srt[n/2];
        return 16'((({1'b0, srt[n/2-1]}) + {1'b0, srt[n/2]}) >> 1);
    endfunction

    task automatic rate_step(input logic [15:0] dly, input logic [30:0] cur,
                             input logic [31:0] elapsed);
        longint up, down, len, med, bs, tgt, hp, d, r;
        int mul;
        up = p_up_div;
        down = p_down_div;
        if (elapsed < lburc_pkg::T20) mul = 4;
        else if (elapsed < lburc_pkg::T30) mul = 1;
        else if (elapsed < lburc_pkg::T40) mul = 2;
        else if (elapsed < lburc_pkg::T60) mul = 3;
        else mul = 0;
        if (mul != 0) begin
            up = up * mul / 4;
            down = down * mul / 4;
        end
        if (up < 1) up = 1;
        if (down < 1) down = 1;
        if (p_use_ms) tgt = p_tol;
        else tgt = (longint'(p_base) * p_tol) >>> 8;
        if (dly > 0 && dly < p_base && p_base > p_floor)
            p_base = (dly > p_floor) ? 31'(dly) : 31'(p_floor);
        len = p_win_len;
        if (len < 1) len = 1;
        if (len > WMAX) len = WMAX;
        while (p_count >= len) begin
            p_head = p_head + 1;
            p_count = p_count - 1;
        end
        p_win[(p_head + p_count) % WMAX] = dly;
        p_count = p_count + 1;
        med = window_median();
        bs = (p_base != 0) ? p_base : 1;
        hp = tgt - (med - longint'(p_base));
        r = p_rate;
        if (hp < 0) begin
            d = hp * 10240 / down / bs;
            p_accept = 1'b0;
            r = (r > -d) ? r + d : 0;
        end else if (hp > 0) begin
            p_accept = 1'b1;
            if (longint'(cur) + lburc_pkg::HEADROOM > r) begin
                d = hp * 10240 / (up * bs);
                r = ((longint'(lburc_pkg::RATE_MAX) - r) > d) ? r + d
                                                              : longint'(lburc_pkg::RATE_MAX);
            end
        end
        p_rate = 31'(r);
        if (p_rate < p_min_up) begin
            p_rate = p_min_up;
            p_accept = 1'b1;
        end
        if (p_rate > p_max_up) p_rate = p_max_up;
    endtask

    task automatic predict_limit(input rate_req_t rq);
        rate_res_t res;
        logic [30:0] u;
        case (rq.action)
            lburc_pkg::ACT_RESET: begin
                p_count = 0;
                p_head = 0;
                p_base = lburc_pkg::RATE_MAX;
            end
            lburc_pkg::ACT_CALIB: begin
                if (rq.delay_ms > 0 && rq.delay_ms < p_base)
                    p_base = (rq.delay_ms > p_floor) ? 31'(rq.delay_ms) : 31'(p_floor);
            end
            lburc_pkg::ACT_BEGIN: begin
                u = (rq.cur_upload > p_min_up) ? rq.cur_upload : p_min_up;
                if (p_base == lburc_pkg::RATE_MAX) p_base = 31'(p_floor);
                p_rate = (u < p_max_up) ? u : p_max_up;
                p_count = 0;
                p_head = 0;
                p_start = rq.now_ms;
            end
            lburc_pkg::ACT_CTRL:
                rate_step(rq.delay_ms, rq.cur_upload, rq.now_ms - p_start);
            lburc_pkg::ACT_FAST: begin
                p_start = rq.now_ms;
                rate_step(rq.delay_ms, rq.cur_upload, 32'd0);
            end
            default: ;
        endcase
        res.upload_limit = p_rate;
        res.accept = p_accept;
        res.median = window_median();
        res.baseline = p_base;
        limit_q.push_back(res);
    endtask

    // sender: bursts with random gaps
    int gap_left = 0, burst_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_limit(rate_req_t'({s_tuser, s_tdata[15:0], s_tdata[46:16],
                                           s_tdata[78:47]}));
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0 || sender_pause || req_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    rate_req_t rq;
                    rq = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= rq.action;
                    s_tdata <= {1'b0, rq.now_ms, rq.cur_upload, rq.delay_ms};
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                    end
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int stall_mode = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            if (long_hold) m_tready <= 1'b0;
            else case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rate_res_t got, exp_r;
            got.upload_limit = m_tdata[30:0];
            got.accept = m_tdata[31];
            got.median = m_tdata[47:32];
            got.baseline = m_tdata[78:48];
            if (limit_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                exp_r = limit_q.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp lim=%0d acc=%0b med=%0d base=%0d ",
                                  "got lim=%0d acc=%0b med=%0d base=%0d"},
                            exp_r.upload_limit, exp_r.accept, exp_r.median, exp_r.baseline,
                            got.upload_limit, got.accept, got.median, got.baseline);
                end
            end
        end
    end

    function automatic rate_req_t make_req(input logic [2:0] a, input logic [15:0] d,
                                           input logic [30:0] c, input logic [31:0] t);
        rate_req_t rq;
        rq.action = a; rq.delay_ms = d; rq.cur_upload = c; rq.now_ms = t;
        return rq;
    endfunction

    task automatic wait_drained();
        while (req_q.size() != 0 || s_tvalid || limit_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(input lburc_pkg::cfg_idx_t idx, input logic [30:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            lburc_pkg::REG_USE_MS:    p_use_ms = val[0];
            lburc_pkg::REG_TOLERANCE: p_tol = val[15:0];
            lburc_pkg::REG_UP_DIV:    p_up_div = val[15:0];
            lburc_pkg::REG_DOWN_DIV:  p_down_div = val[15:0];
            lburc_pkg::REG_WIN_LEN:   p_win_len = val[5:0];
            lburc_pkg::REG_FLOOR:     p_floor = val[15:0];
            lburc_pkg::REG_MIN_UP:    p_min_up = val;
            lburc_pkg::REG_MAX_UP:    p_max_up = val;
            default: ;
        endcase
    endtask

    // one session: optional reset and calibrations, begin, then mostly control samples with rising time stamps
    task automatic queue_session(input int n);
        logic [31:0] t;
        int k, sel;
        t = $urandom;
        if ($urandom_range(0, 3) == 0)
            req_q.push_back(make_req(lburc_pkg::ACT_RESET, 0, 0, t));
        repeat ($urandom_range(0, 3))
            req_q.push_back(make_req(lburc_pkg::ACT_CALIB, $urandom_range(0, 400), 0, t));
        req_q.push_back(make_req(lburc_pkg::ACT_BEGIN, 0, $urandom_range(0, 2000000), t));
        for (k = 0; k < n; k++) begin
            t = t + $urandom_range(0, 9000);
            sel = $urandom_range(0, 19);
            if (sel == 0)
                req_q.push_back(make_req(3'($urandom_range(5, 7)), $urandom, $urandom,
                                         $urandom));
            else if (sel == 1)
                req_q.push_back(make_req(lburc_pkg::ACT_FAST, $urandom_range(0, 500),
                                         $urandom_range(0, 3000000), t));
            else if (sel == 2)
                req_q.push_back(make_req(lburc_pkg::ACT_CTRL, $urandom, $urandom, t));
            else if (sel == 3)
                req_q.push_back(make_req(lburc_pkg::ACT_CALIB, $urandom_range(0, 300), 0, t));
            else
                req_q.push_back(make_req(lburc_pkg::ACT_CTRL, $urandom_range(0, 600),
                                         $urandom_range(0, 3000000), t));
        end
    endtask

    task automatic random_config();
        write_reg(lburc_pkg::REG_USE_MS, $urandom_range(0, 1));
        write_reg(lburc_pkg::REG_TOLERANCE,
                  ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 800));
        write_reg(lburc_pkg::REG_UP_DIV,
                  ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 8));
        write_reg(lburc_pkg::REG_DOWN_DIV,
                  ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 8));
        write_reg(lburc_pkg::REG_WIN_LEN, $urandom_range(0, 63));
        write_reg(lburc_pkg::REG_FLOOR,
                  ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 60));
        write_reg(lburc_pkg::REG_MIN_UP,
                  ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 50000));
        write_reg(lburc_pkg::REG_MAX_UP,
                  ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(40000, 5000000));
    endtask

    // run limit
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int ph, k;
        p_use_ms = 0; p_tol = 200; p_up_div = 1; p_down_div = 1; p_win_len = 1;
        p_floor = 20; p_min_up = 1024; p_max_up = lburc_pkg::RATE_MAX;
        p_base = lburc_pkg::RATE_MAX; p_rate = 0; p_count = 0; p_head = 0; p_start = 0;
        p_accept = 0;
        for (k = 0; k < WMAX; k++) p_win[k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: control before begin, calibration corners, extremes
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'd50, 31'd0, 32'd0));
        req_q.push_back(make_req(lburc_pkg::ACT_CALIB, 16'd0, 31'd0, 32'd0));
        req_q.push_back(make_req(lburc_pkg::ACT_CALIB, 16'd5, 31'd0, 32'd0));
        req_q.push_back(make_req(lburc_pkg::ACT_CALIB, 16'hFFFF, lburc_pkg::RATE_MAX,
                                 32'hFFFF_FFFF));
        req_q.push_back(make_req(lburc_pkg::ACT_RESET, 16'hFFFF, lburc_pkg::RATE_MAX,
                                 32'hFFFF_FFFF));
        req_q.push_back(make_req(lburc_pkg::ACT_BEGIN, 16'd0, 31'd0, 32'hFFFF_FFF0));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'hFFFF, 31'd0, 32'd100));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'd0, lburc_pkg::RATE_MAX, 32'd25000));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'd30, lburc_pkg::RATE_MAX, 32'd35000));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'd30, lburc_pkg::RATE_MAX, 32'd45000));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'd30, lburc_pkg::RATE_MAX, 32'd70000));
        req_q.push_back(make_req(lburc_pkg::ACT_FAST, 16'd25, lburc_pkg::RATE_MAX, 32'd80000));
        req_q.push_back(make_req(3'd5, 16'd1, 31'd1, 32'd1));
        req_q.push_back(make_req(3'd7, 16'hFFFF, lburc_pkg::RATE_MAX, 32'hFFFF_FFFF));
        req_q.push_back(make_req(lburc_pkg::ACT_BEGIN, 16'd0, lburc_pkg::RATE_MAX, 32'd0));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'd1, lburc_pkg::RATE_MAX, 32'd1));
        wait_drained();

        // zero divisors, zero floor, min above max, ms tolerance, full window
        write_reg(lburc_pkg::REG_USE_MS, 1); write_reg(lburc_pkg::REG_TOLERANCE, 16'hFFFF);
        write_reg(lburc_pkg::REG_UP_DIV, 0); write_reg(lburc_pkg::REG_DOWN_DIV, 0);
        write_reg(lburc_pkg::REG_WIN_LEN, 63); write_reg(lburc_pkg::REG_FLOOR, 0);
        write_reg(lburc_pkg::REG_MIN_UP, lburc_pkg::RATE_MAX);
        write_reg(lburc_pkg::REG_MAX_UP, 31'd0);
        req_q.push_back(make_req(lburc_pkg::ACT_RESET, 0, 0, 0));
        req_q.push_back(make_req(lburc_pkg::ACT_BEGIN, 0, 31'd5000, 32'd0));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'd40, 31'd1, 32'd10));
        wait_drained();
        write_reg(lburc_pkg::REG_MIN_UP, 31'd0);
        write_reg(lburc_pkg::REG_MAX_UP, lburc_pkg::RATE_MAX);
        write_reg(lburc_pkg::REG_TOLERANCE, 16'd0);
        req_q.push_back(make_req(lburc_pkg::ACT_CALIB, 16'd0, 0, 0));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'd0, 31'd0, 32'd10));
        req_q.push_back(make_req(lburc_pkg::ACT_CTRL, 16'hFFFF, 31'd0, 32'd20));
        wait_drained();

        // random phases; one receiver hold-off while the sender keeps offering
        for (ph = 0; ph < 24; ph++) begin
            random_config();
            if (ph == 3) begin
                queue_session(40);
                long_hold = 1;
                repeat (3000) @(posedge aclk);
                long_hold = 0;
            end else if (ph == 6) begin
                queue_session(40);
                repeat (300) @(posedge aclk);
                sender_pause = 1;
                while (limit_q.size() != 0 || s_tvalid) @(posedge aclk);
                repeat ($urandom_range(1, 50)) @(posedge aclk);
                sender_pause = 0;
            end else begin
                for (k = 0; k < 4; k++) queue_session($urandom_range(8, 28));
            end
            wait_drained();
        end

        feed_done = 1;
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
